### sv/jhksm_pkg.sv
`timescale 1ns / 1ps

package jhksm_pkg;

   localparam int MAX_CANDIDATES = 64;
   localparam int MAX_DIGITS     = 6;
   localparam int KEY_LEN        = 7;

   localparam int MODE_W   = 2;
   localparam int BYTE_W   = 8;
   localparam int SLOT_W   = 6;
   localparam int VALUE_W  = 24;
   localparam int MASK_W   = 64;
   localparam int COUNT_W  = 7;
   localparam int ENTRY_W  = 32;
   localparam int NIBBLE_W = 4;

   localparam int DIGIT_W    = $clog2(MAX_DIGITS + 1);
   localparam int POS_W      = $clog2(KEY_LEN);
   localparam int TBL_IDX_W  = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
   localparam int GROUP_SIZE = 8;
   localparam int GROUP_COUNT = (MAX_CANDIDATES + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int GROUP_CNT_W = $clog2(GROUP_SIZE + 1);
   localparam int PAD_W       = GROUP_COUNT * GROUP_SIZE;

   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   localparam logic [BYTE_W-1:0] QUOTE_BYTE = 8'h22;

   typedef enum logic [MODE_W-1:0] {
      MODE_START  = 2'd0,
      MODE_LOAD   = 2'd1,
      MODE_STREAM = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      CMD_START,
      CMD_LOAD,
      CMD_REPORT,
      CMD_MATCH
   } cmd_kind_type;

   typedef struct packed {
      mode_type            mode;
      logic [BYTE_W-1:0]   stream_byte;
      logic [SLOT_W-1:0]   candidate_index;
      logic [VALUE_W-1:0]  candidate_value;
   } req_type;

   typedef struct packed {
      logic [MASK_W-1:0]   found_mask;
      logic [COUNT_W-1:0]  found_count;
      logic                all_found;
      logic                value_completed;
      logic [ENTRY_W-1:0]  entries_seen;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [SLOT_W-1:0]   slot;
      logic [VALUE_W-1:0]  value;
   } cmd_type;

   typedef struct packed {
      logic                valid;
      logic [NIBBLE_W-1:0] value;
   } nibble_type;

   // Key pattern: quote h e x quote colon quote
   function automatic logic [BYTE_W-1:0] key_byte(input logic [POS_W-1:0] pos);
      logic [BYTE_W-1:0] b;
      unique case (pos)
         3'd0:    b = QUOTE_BYTE;
         3'd1:    b = 8'h68;
         3'd2:    b = 8'h65;
         3'd3:    b = 8'h78;
         3'd4:    b = QUOTE_BYTE;
         3'd5:    b = 8'h3A;
         3'd6:    b = QUOTE_BYTE;
         default: b = QUOTE_BYTE;
      endcase
      return b;
   endfunction

   function automatic nibble_type hex_nibble(input logic [BYTE_W-1:0] c);
      nibble_type n;
      n.valid = 1'b1;
      n.value = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         n.value = NIBBLE_W'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         n.value = NIBBLE_W'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         n.value = NIBBLE_W'(c - 8'h37);
      end else begin
         n.valid = 1'b0;
      end
      return n;
   endfunction

   function automatic logic [GROUP_CNT_W-1:0] group_ones(input logic [GROUP_SIZE-1:0] v);
      logic [GROUP_CNT_W-1:0] s;
      s = '0;
      for (int i = 0; i < GROUP_SIZE; i++) begin
         s = s + GROUP_CNT_W'(v[i]);
      end
      return s;
   endfunction

endpackage

### sv/jhksm_front.sv
`timescale 1ns / 1ps

module jhksm_front
   import jhksm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req_data,
   output logic    cmd_push,
   output cmd_type cmd_data
);

   logic                in_value_ff,  in_value_in;
   logic [POS_W-1:0]    match_pos_ff, match_pos_in;
   logic [VALUE_W-1:0]  value_ff,     value_in;
   logic [DIGIT_W-1:0]  digits_ff,    digits_in;
   nibble_type          nib;

   assign nib      = hex_nibble(req_data.stream_byte);
   assign cmd_push = accept;

   always_comb begin
      in_value_in    = in_value_ff;
      match_pos_in   = match_pos_ff;
      value_in       = value_ff;
      digits_in      = digits_ff;
      cmd_data.kind  = CMD_REPORT;
      cmd_data.slot  = req_data.candidate_index;
      cmd_data.value = req_data.candidate_value;
      if (accept) begin
         unique case (req_data.mode)
            MODE_START: begin
               cmd_data.kind = CMD_START;
               in_value_in   = 1'b0;
               match_pos_in  = '0;
               value_in      = '0;
               digits_in     = '0;
            end
            MODE_LOAD: begin
               cmd_data.kind = CMD_LOAD;
            end
            MODE_STREAM: begin
               if (!in_value_ff) begin
                  if (req_data.stream_byte == key_byte(match_pos_ff)) begin
                     if (match_pos_ff == POS_W'(KEY_LEN - 1)) begin
                        in_value_in  = 1'b1;
                        match_pos_in = '0;
                        value_in     = '0;
                        digits_in    = '0;
                     end else begin
                        match_pos_in = match_pos_ff + POS_W'(1);
                     end
                  end else begin
                     // fall back: a quote may open the key again
                     match_pos_in = (req_data.stream_byte == QUOTE_BYTE) ? POS_W'(1) : '0;
                  end
               end else if (req_data.stream_byte == QUOTE_BYTE) begin
                  if (digits_ff != '0) begin
                     cmd_data.kind  = CMD_MATCH;
                     cmd_data.value = value_ff;
                  end
                  in_value_in = 1'b0;
                  value_in    = '0;
                  digits_in   = '0;
               end else if (nib.valid) begin
                  // extra digits beyond the limit are dropped
                  if (digits_ff < DIGIT_W'(MAX_DIGITS)) begin
                     value_in  = {value_ff[VALUE_W-NIBBLE_W-1:0], nib.value};
                     digits_in = digits_ff + DIGIT_W'(1);
                  end
               end else begin
                  in_value_in = 1'b0;
                  value_in    = '0;
                  digits_in   = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_value_ff  <= 1'b0;
         match_pos_ff <= '0;
         value_ff     <= '0;
         digits_ff    <= '0;
      end else begin
         in_value_ff  <= in_value_in;
         match_pos_ff <= match_pos_in;
         value_ff     <= value_in;
         digits_ff    <= digits_in;
      end
   end

endmodule

### sv/jhksm_cmd_fifo.sv
`timescale 1ns / 1ps

module jhksm_cmd_fifo
   import jhksm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   cmd_type               entry_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0] count_ff,  count_in;
   logic                  do_push, do_pop;

   assign full     = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                                : wr_ptr_ff + CMDQ_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                                : rd_ptr_ff + CMDQ_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CMDQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CMDQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/jhksm_back.sv
`timescale 1ns / 1ps

module jhksm_back
   import jhksm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  cmd_type            cmd_data,
   output logic               cmd_pop,
   input  logic [COUNT_W-1:0] candidate_count,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output rsp_type            rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_MERGE
   } back_state_type;

   back_state_type            state_ff, state_in;
   logic [VALUE_W-1:0]        table_ff [MAX_CANDIDATES];
   logic [MAX_CANDIDATES-1:0] flags_ff, flags_in;
   logic [COUNT_W-1:0]        total_ff, total_in;
   logic [ENTRY_W-1:0]        entries_ff, entries_in;
   logic [MAX_CANDIDATES-1:0] hit_ff, hit_in;
   logic [GROUP_CNT_W-1:0]    group_ff [GROUP_COUNT];
   logic [GROUP_CNT_W-1:0]    group_in [GROUP_COUNT];
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic [MAX_CANDIDATES-1:0] active;
   logic [MAX_CANDIDATES-1:0] equal;
   logic [PAD_W-1:0]          hit_pad;
   logic [COUNT_W-1:0]        group_sum;
   logic [COUNT_W-1:0]        active_limit;
   logic                      out_free;
   logic                      table_we;

   assign out_free     = !rsp_valid_ff || rsp_pop;
   assign rsp_empty    = !rsp_valid_ff;
   assign rsp_data     = rsp_ff;
   assign hit_pad      = PAD_W'(hit_ff);
   assign active_limit = (candidate_count > COUNT_W'(MAX_CANDIDATES)) ? COUNT_W'(MAX_CANDIDATES)
                                                                       : candidate_count;

   // one comparator per table slot
   always_comb begin
      for (int i = 0; i < MAX_CANDIDATES; i++) begin
         active[i] = (COUNT_W'(i) < candidate_count);
         equal[i]  = (table_ff[i] == cmd_data.value);
      end
   end

   always_comb begin
      group_sum = '0;
      for (int g = 0; g < GROUP_COUNT; g++) begin
         group_sum = group_sum + COUNT_W'(group_ff[g]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      flags_in     = flags_ff;
      total_in     = total_ff;
      entries_in   = entries_ff;
      hit_in       = hit_ff;
      group_in     = group_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      table_we     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd_data.kind == CMD_MATCH) begin
               cmd_pop    = 1'b1;
               hit_in     = active & ~flags_ff & equal;
               entries_in = (entries_ff == '1) ? entries_ff : entries_ff + ENTRY_W'(1);
               state_in   = ST_SUM;
            end else if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               unique case (cmd_data.kind)
                  CMD_START: begin
                     flags_in   = '0;
                     total_in   = '0;
                     entries_in = '0;
                  end
                  CMD_LOAD: begin
                     table_we = (cmd_data.slot < SLOT_W'(MAX_CANDIDATES)) ||
                                (MAX_CANDIDATES > (1 << SLOT_W) - 1);
                  end
                  default: begin
                  end
               endcase
               rsp_valid_in           = 1'b1;
               rsp_in.found_mask      = MASK_W'(flags_in);
               rsp_in.found_count     = total_in;
               rsp_in.all_found       = (total_in >= active_limit);
               rsp_in.value_completed = 1'b0;
               rsp_in.entries_seen    = entries_in;
            end
         end
         ST_SUM: begin
            for (int g = 0; g < GROUP_COUNT; g++) begin
               group_in[g] = group_ones(hit_pad[g*GROUP_SIZE +: GROUP_SIZE]);
            end
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (out_free) begin
               flags_in               = flags_ff | hit_ff;
               total_in               = total_ff + group_sum;
               rsp_valid_in           = 1'b1;
               rsp_in.found_mask      = MASK_W'(flags_in);
               rsp_in.found_count     = total_in;
               rsp_in.all_found       = (total_in >= active_limit);
               rsp_in.value_completed = 1'b1;
               rsp_in.entries_seen    = entries_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flags_ff     <= '0;
         total_ff     <= '0;
         entries_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flags_ff     <= flags_in;
         total_ff     <= total_in;
         entries_ff   <= entries_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hit_ff   <= hit_in;
      group_ff <= group_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (table_we) begin
         table_ff[cmd_data.slot[TBL_IDX_W-1:0]] <= cmd_data.value;
      end
   end

endmodule

### sv/json_hex_key_stream_matcher.sv
`timescale 1ns / 1ps

// Streaming key matcher: feed response bytes (mode stream) and it picks out every
// "hex":"<digits>" value, up to six hex digits of either case, and checks each
// completed value against a table of up to 64 candidate addresses loaded beforehand
// (mode load). Every item gives exactly one beat on the result side: the found mask,
// the number found, an all-found flag against the candidate_count register, whether
// this byte closed a value, and the saturating count of values seen. Mode start clears
// flags, counters and the parser but keeps the table and the register. The front parser
// takes one byte per cycle whenever the two-entry command queue has room; the back end
// retires start, load and plain bytes straight from idle when the result register is free,
// and a completed value in three steps (compare against all slots, per-group popcount,
// merge), so sustained throughput is one byte per cycle between values while results are
// popped, and the queue absorbs the wait of a completion. Write candidate_count only while
// the block is idle; table slots never loaded read as undefined.
module json_hex_key_stream_matcher
   import jhksm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  req_type            req_data,
   output logic               empty,
   input  logic               pop,
   output rsp_type            rsp_data,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data
);

   logic [COUNT_W-1:0] cand_count_ff, cand_count_in;
   logic               accept;
   logic               cmd_push;
   cmd_type            cmd_in_data;
   logic               cmd_full;
   logic               cmd_empty;
   logic               cmd_pop;
   cmd_type            cmd_out_data;

   // accept a beat whenever the command queue has room
   assign full   = cmd_full;
   assign accept = push && !cmd_full;

   // candidate_count register, reset to one slot
   assign cand_count_in = csr_wr_en ? csr_wr_data : cand_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_count_ff <= COUNT_W'(1);
      end else begin
         cand_count_ff <= cand_count_in;
      end
   end

   // front: parse the byte stream, emit one command per accepted beat
   jhksm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd_data (cmd_in_data)
   );

   // decouple parser from matcher
   jhksm_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_data),
      .empty     (cmd_empty)
   );

   // back: candidate table, found flags, counters and the result register
   jhksm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (!cmd_empty),
      .cmd_data        (cmd_out_data),
      .cmd_pop         (cmd_pop),
      .candidate_count (cand_count_ff),
      .rsp_pop         (pop),
      .rsp_empty       (empty),
      .rsp_data        (rsp_data)
   );

`ifndef SYNTHESIS
   // the count must always agree with the flags it summarises
   a_count_matches_mask: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ($countones(rsp_data.found_mask) == rsp_data.found_count))
      else $error("found_count disagrees with found_mask");

   // a completed value has been counted
   a_completion_counted: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.value_completed) |-> (rsp_data.entries_seen != '0))
      else $error("value completed but entries_seen is zero");

   // no more candidates found than table slots
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.found_count <= COUNT_W'(MAX_CANDIDATES)))
      else $error("found_count exceeds table size");
`endif

endmodule
